### rtl/kkt_pkg.sv
package kkt_pkg;

	localparam logic [2:0] CMD_KEY    = 3'd0;
	localparam logic [2:0] CMD_SCAN   = 3'd1;
	localparam logic [2:0] CMD_WRITE  = 3'd2;
	localparam logic [2:0] CMD_READ   = 3'd3;
	localparam logic [2:0] CMD_SETMD  = 3'd4;
	localparam logic [2:0] CMD_GETMD  = 3'd5;
	localparam logic [2:0] CMD_ACT    = 3'd6;

	localparam logic [1:0] MODE_RAW   = 2'd0;
	localparam logic [1:0] MODE_XLATE = 2'd1;
	localparam logic [1:0] MODE_MRAW  = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVAL   = 2'd1;
	localparam logic [1:0] ST_NOCON   = 2'd2;

	localparam logic [15:0] SYM_HOLE      = 16'h0200;
	localparam logic [15:0] SYM_ALLOCATED = 16'h027e;
	localparam logic [15:0] SYM_NOSUCHMAP = 16'h027f;
	localparam logic [7:0]  TYPE_LIMIT    = 8'd15;
	localparam logic [7:0]  ESC_BYTE      = 8'h1b;
	localparam logic [7:0]  HIGH_BIT      = 8'h80;
	localparam logic [7:0]  CR_BYTE       = 8'h0d;
	localparam logic [7:0]  LBRACKET      = 8'h5b;

	localparam logic [7:0] TY_PLAIN  = 8'd0;
	localparam logic [7:0] TY_SPEC   = 8'd2;
	localparam logic [7:0] TY_CONS   = 8'd5;
	localparam logic [7:0] TY_CUR    = 8'd6;
	localparam logic [7:0] TY_MODKEY = 8'd7;
	localparam logic [7:0] TY_ALPHA  = 8'd11;

	function automatic logic [7:0] cursor_letter(input logic [1:0] v);
		case (v)
			2'd0: cursor_letter = 8'h42;
			2'd1: cursor_letter = 8'h44;
			2'd2: cursor_letter = 8'h43;
			default: cursor_letter = 8'h41;
		endcase
	endfunction

	// controller -> datapath
	typedef struct packed {
		logic latch;    // capture the command fields
		logic mem_rd;   // read store at lookup address
		logic fill_wr;  // write one fill slot
		logic ent_wr;   // write requested entry
		logic fill_clr; // reset fill counter
		logic exec;     // apply state updates and build results
		logic emit;     // present next queued result
	} kkt_ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic need_rd;
		logic need_fill;
		logic need_wr;
		logic fill_done;
		logic more;     // results remain to emit
	} kkt_sts_t;

endpackage

### rtl/kkt_datapath.sv
module kkt_datapath #(
	parameter int MAP_COUNT = 256,
	parameter int KEY_COUNT = 256,
	parameter int CONSOLE_COUNT = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  kkt_pkg::kkt_ctl_t ctl,
	output kkt_pkg::kkt_sts_t sts,
	input  logic [2:0] cmd,
	input  logic [7:0] key_code,
	input  logic key_down,
	input  logic [7:0] scan_byte,
	input  logic [7:0] map_select,
	input  logic [7:0] entry_slot,
	input  logic [15:0] entry_word,
	input  logic [3:0] console_index,
	input  logic [1:0] mode_code,
	output logic strobe,
	output logic [7:0] out_byte,
	output logic byte_valid,
	output logic [3:0] target_console,
	output logic [15:0] read_word,
	output logic [1:0] status,
	output logic last
);
	import kkt_pkg::*;

	localparam int MW = (MAP_COUNT > 1) ? $clog2(MAP_COUNT) : 1;
	localparam int KW = $clog2(KEY_COUNT);
	localparam int AW = MW + KW;
	localparam int CW = (CONSOLE_COUNT > 1) ? $clog2(CONSOLE_COUNT) : 1;

	// each map occupies a power-of-two slot range
	logic [15:0] mem [MAP_COUNT*(1<<KW)];
	logic [15:0] rd_q;

	logic [2:0] cmd_q;
	logic [7:0] code_q, scan_q, map_q, slot_q;
	logic down_q;
	logic [15:0] word_q;
	logic [3:0] con_q;
	logic [1:0] mcode_q;

	logic [MAP_COUNT-1:0] present_q;
	logic [7:0] mod_q;
	logic [3:0] act_q;
	logic [1:0] modes_q [CONSOLE_COUNT];
	logic [KW:0] fill_q;

	logic [7:0] rb_q [3];
	logic [1:0] rn_q, ri_q;
	logic [15:0] rw_q;
	logic [1:0] rs_q;
	logic rv_q;

	logic [1:0] mode;
	logic map_ok, rmap_ok;
	logic [AW-1:0] lk_addr, wr_addr;
	logic wr_ok, remove;

	always_comb begin
		// act_q only ever holds a valid console
		mode = (32'(act_q) < CONSOLE_COUNT) ? modes_q[act_q[CW-1:0]] : MODE_XLATE;
		map_ok = (32'(mod_q) < MAP_COUNT) && present_q[mod_q[MW-1:0]];
		rmap_ok = (32'(map_q) < MAP_COUNT) && (32'(slot_q) < KEY_COUNT);
		if (cmd_q == CMD_READ)
			lk_addr = {map_q[MW-1:0], slot_q[KW-1:0]};
		else
			lk_addr = {mod_q[MW-1:0], code_q[KW-1:0]};
		remove = (slot_q == 8'd0) && (word_q == SYM_NOSUCHMAP);
		wr_ok = (32'(map_q) < MAP_COUNT) && !remove && (word_q[15:8] < TYPE_LIMIT)
			&& (slot_q != 8'd0) && (32'(slot_q) < KEY_COUNT);
		if (ctl.fill_wr)
			wr_addr = {map_q[MW-1:0], fill_q[KW-1:0]};
		else
			wr_addr = {map_q[MW-1:0], slot_q[KW-1:0]};
		sts.need_rd = (cmd_q == CMD_READ) ? (rmap_ok && present_q[map_q[MW-1:0]])
			: ((cmd_q == CMD_KEY) && mode == MODE_XLATE && map_ok
			&& 32'(code_q) < KEY_COUNT);
		sts.need_wr = (cmd_q == CMD_WRITE) && wr_ok;
		sts.need_fill = sts.need_wr && !present_q[map_q[MW-1:0]];
		sts.fill_done = (32'(fill_q) == KEY_COUNT);
		sts.more = (ri_q < rn_q);
	end

	always_ff @(posedge clk) begin
		if (ctl.mem_rd)
			rd_q <= mem[lk_addr];
		if (ctl.fill_wr)
			mem[wr_addr] <= (fill_q == '0) ? SYM_ALLOCATED : SYM_HOLE;
		else if (ctl.ent_wr)
			mem[wr_addr] <= word_q;
	end

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q <= cmd; code_q <= key_code; down_q <= key_down; scan_q <= scan_byte;
			map_q <= map_select; slot_q <= entry_slot; word_q <= entry_word;
			con_q <= console_index; mcode_q <= mode_code;
		end
	end

	logic [7:0] sv_type, sv_val;
	assign sv_type = rd_q[15:8];
	assign sv_val = rd_q[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			mod_q <= '0;
			act_q <= '0;
			for (int i = 0; i < CONSOLE_COUNT; i++) modes_q[i] <= MODE_XLATE;
			fill_q <= '0;
			for (int i = 0; i < 3; i++) rb_q[i] <= '0;
			rn_q <= '0;
			ri_q <= '0;
			rv_q <= 1'b0;
			rw_q <= '0;
			rs_q <= ST_OK;
			strobe <= 1'b0;
			out_byte <= '0;
			byte_valid <= 1'b0;
			target_console <= '0;
			read_word <= '0;
			status <= ST_OK;
			last <= 1'b0;
		end else begin
			strobe <= 1'b0;
			if (ctl.fill_clr) fill_q <= '0;
			else if (ctl.fill_wr) fill_q <= fill_q + 1'b1;
			if (ctl.fill_wr && sts.fill_done == 1'b0 && 32'(fill_q) == KEY_COUNT - 1)
				present_q[map_q[MW-1:0]] <= 1'b1;
			if (ctl.exec) begin
				rn_q <= 2'd0; ri_q <= 2'd0; rv_q <= 1'b1; rw_q <= '0; rs_q <= ST_OK;
				case (cmd_q)
					CMD_KEY: begin
						if (mode == MODE_XLATE && sts.need_rd) begin
							case (sv_type)
								TY_PLAIN, TY_ALPHA: if (down_q) begin
									rb_q[0] <= sv_val; rn_q <= 2'd1;
								end
								TY_SPEC: if (down_q && sv_val == 8'd1) begin
									rb_q[0] <= CR_BYTE; rn_q <= 2'd1;
								end
								TY_CONS: if (down_q && 32'(sv_val) < CONSOLE_COUNT)
									act_q <= sv_val[3:0];
								TY_CUR: if (down_q && sv_val < 8'd4) begin
									rb_q[0] <= ESC_BYTE; rb_q[1] <= LBRACKET;
									rb_q[2] <= cursor_letter(sv_val[1:0]); rn_q <= 2'd3;
								end
								TY_MODKEY: if (sv_val <= 8'd8) begin
									if (down_q) mod_q[sv_val[2:0]] <= 1'b1;
									else mod_q[sv_val[2:0]] <= 1'b0;
								end
								default: ;
							endcase
						end else if (mode == MODE_MRAW) begin
							if (!code_q[7]) begin
								rb_q[0] <= code_q | (down_q ? 8'h00 : HIGH_BIT);
								rn_q <= 2'd1;
							end else begin
								rb_q[0] <= down_q ? 8'h00 : HIGH_BIT;
								rb_q[1] <= 8'h81;
								rb_q[2] <= code_q | HIGH_BIT;
								rn_q <= 2'd3;
							end
						end
					end
					CMD_SCAN: if (mode == MODE_RAW) begin
						rb_q[0] <= scan_q; rn_q <= 2'd1;
					end
					default: begin
						rv_q <= 1'b0; rb_q[0] <= 8'h00; rn_q <= 2'd1;
						case (cmd_q)
							CMD_WRITE: begin
								if (32'(map_q) >= MAP_COUNT) rs_q <= ST_INVAL;
								else if (remove) begin
									if (map_q != 8'd0) present_q[map_q[MW-1:0]] <= 1'b0;
								end else if (!wr_ok) rs_q <= ST_INVAL;
							end
							CMD_READ: begin
								if (!rmap_ok) rs_q <= ST_INVAL;
								else if (present_q[map_q[MW-1:0]])
									rw_q <= (rd_q[15:8] >= TYPE_LIMIT) ? SYM_HOLE : rd_q;
								else rw_q <= (slot_q != 8'd0) ? SYM_HOLE : SYM_NOSUCHMAP;
							end
							CMD_SETMD: begin
								if (32'(con_q) >= CONSOLE_COUNT) rs_q <= ST_NOCON;
								else if (mcode_q == 2'd3) rs_q <= ST_INVAL;
								else modes_q[con_q[CW-1:0]] <= mcode_q;
							end
							CMD_GETMD: begin
								if (32'(con_q) >= CONSOLE_COUNT) rs_q <= ST_NOCON;
								else rw_q <= {14'd0, modes_q[con_q[CW-1:0]]};
							end
							CMD_ACT: begin
								if (32'(con_q) >= CONSOLE_COUNT) rs_q <= ST_NOCON;
								else act_q <= con_q;
							end
							default: rs_q <= ST_INVAL;
						endcase
					end
				endcase
			end
			if (ctl.emit) begin
				strobe <= 1'b1;
				out_byte <= rb_q[ri_q];
				byte_valid <= rv_q;
				target_console <= act_q;
				read_word <= rw_q;
				status <= rs_q;
				last <= (ri_q + 2'd1 == rn_q);
				ri_q <= ri_q + 2'd1;
			end
		end
	end
endmodule

### rtl/kkt_ctrl.sv
module kkt_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  kkt_pkg::kkt_sts_t sts,
	output kkt_pkg::kkt_ctl_t ctl
);
	import kkt_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_FILL = 3'd2;
	localparam logic [2:0] S_WAIT = 3'd3;
	localparam logic [2:0] S_EXEC = 3'd4;
	localparam logic [2:0] S_EMIT = 3'd5;

	logic [2:0] st_q, st_d;

	always_comb begin
		ctl = '0;
		st_d = st_q;
		busy = (st_q != S_IDLE);
		case (st_q)
			S_IDLE: if (start) begin
				ctl.latch = 1'b1; st_d = S_DEC;
			end
			S_DEC: begin
				ctl.fill_clr = 1'b1;
				if (sts.need_fill) st_d = S_FILL;
				else begin
					ctl.ent_wr = sts.need_wr;
					ctl.mem_rd = sts.need_rd;
					st_d = S_WAIT;
				end
			end
			S_FILL: begin
				if (sts.fill_done) begin
					ctl.ent_wr = 1'b1; st_d = S_WAIT;
				end else ctl.fill_wr = 1'b1;
			end
			S_WAIT: st_d = S_EXEC;
			S_EXEC: begin
				ctl.exec = 1'b1; st_d = S_EMIT;
			end
			S_EMIT: begin
				if (sts.more) ctl.emit = 1'b1;
				else st_d = S_IDLE;
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= S_IDLE;
		else st_q <= st_d;
	end
endmodule

### rtl/keyboard_keymap_translator_unit.sv
// After an item is accepted the controller steps through decode, wait, execute and
// emit; a write to an absent map first fills every slot of that map through the
// single store port, then writes the entry. Results are strobed on consecutive
// cycles. A new item is accepted only while busy is low, after the last result.
// Reset (arst_n low, async): all maps absent, modifiers 0, console 0,
// every console in translate mode. Results cannot be stalled by the receiver.
module keyboard_keymap_translator_unit #(
	parameter int MAP_COUNT = 256,
	parameter int KEY_COUNT = 256,
	parameter int CONSOLE_COUNT = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [2:0] cmd,
	input  logic [7:0] key_code,
	input  logic key_down,
	input  logic [7:0] scan_byte,
	input  logic [7:0] map_select,
	input  logic [7:0] entry_slot,
	input  logic [15:0] entry_word,
	input  logic [3:0] console_index,
	input  logic [1:0] mode_code,
	output logic strobe,
	output logic [7:0] out_byte,
	output logic byte_valid,
	output logic [3:0] target_console,
	output logic [15:0] read_word,
	output logic [1:0] status,
	output logic last
);
	import kkt_pkg::*;

	kkt_ctl_t ctl;
	kkt_sts_t sts;

	kkt_ctrl u_ctrl (.clk, .arst_n, .start, .busy, .sts, .ctl);

	kkt_datapath #(.MAP_COUNT(MAP_COUNT), .KEY_COUNT(KEY_COUNT),
		.CONSOLE_COUNT(CONSOLE_COUNT)) u_dp (
		.clk, .arst_n, .ctl, .sts, .cmd, .key_code, .key_down, .scan_byte,
		.map_select, .entry_slot, .entry_word, .console_index, .mode_code,
		.strobe, .out_byte, .byte_valid, .target_console, .read_word, .status, .last);
endmodule

### rtl/kkt_checker.sv
module kkt_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic strobe,
	input logic byte_valid,
	input logic [1:0] status,
	input logic last
);
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy) else $error("result outside busy");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("no busy after accept");
	a_reply_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !byte_valid) |-> last) else $error("reply not last");
	a_byte_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && byte_valid) |-> status == 2'd0) else $error("byte with status");
endmodule

bind keyboard_keymap_translator_unit kkt_checker u_chk (.clk, .arst_n, .start, .busy,
	.strobe, .byte_valid, .status, .last);

### tb/tb_keyboard_keymap_translator_unit.sv
`timescale 1ns / 100ps

module tb_keyboard_keymap_translator_unit;
	import kkt_pkg::*;

	localparam int MAPS = 256;
	localparam int KEYS = 256;
	localparam int CONS = 12;
	localparam int TIMEOUT_CYCLES = 1000000;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        byte_valid;
		logic [3:0]  target_console;
		logic [15:0] read_word;
		logic [1:0]  status;
		logic        last;
	} xlat_result_t;

	typedef struct {
		logic [2:0]  cmd;
		logic [7:0]  key_code;
		logic        key_down;
		logic [7:0]  scan_byte;
		logic [7:0]  map_select;
		logic [7:0]  entry_slot;
		logic [15:0] entry_word;
		logic [3:0]  console_index;
		logic [1:0]  mode_code;
	} kbd_item_t;

	int error_count;

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("%0t: mismatch %s got %h want %h", $realtime, what, got, want);
		error_count++;
	endtask

	class keymap_scoreboard;
		logic [15:0] sym_store [int];
		bit          map_live [MAPS];
		logic [7:0]  mods;
		logic [3:0]  active_con;
		logic [1:0]  con_mode [CONS];
		xlat_result_t pending [$];
		int          bytes_seen;
		int          replies_seen;

		function void clear();
			sym_store.delete();
			foreach (map_live[i]) map_live[i] = 0;
			foreach (con_mode[i]) con_mode[i] = MODE_XLATE;
			mods = 0;
			active_con = 0;
			pending.delete();
		endfunction

		function void push_byte(logic [7:0] b);
			xlat_result_t r;
			r = '0;
			r.out_byte = b;
			r.byte_valid = 1;
			pending.push_back(r);
		endfunction

		function void translate(logic [7:0] code, logic down);
			logic [15:0] sym;
			logic [7:0] kt, kv;
			if (!map_live[mods]) return;
			sym = sym_store[{mods, code}];
			kt = sym[15:8];
			kv = sym[7:0];
			case (kt)
				TY_PLAIN, TY_ALPHA: if (down) push_byte(kv);
				TY_SPEC: if (down && kv == 1) push_byte(CR_BYTE);
				TY_CONS: if (down && kv < CONS) active_con = kv[3:0];
				TY_CUR: if (down && kv < 4) begin
					push_byte(ESC_BYTE);
					push_byte(LBRACKET);
					push_byte(cursor_letter(kv[1:0]));
				end
				TY_MODKEY: begin
					if (kv == 8) kv = 0;
					if (kv < 8) begin
						if (down) mods = mods | (8'd1 << kv);
						else mods = mods & ~(8'd1 << kv);
					end
				end
				default: ;
			endcase
		endfunction

		function logic [1:0] write_sym(logic [7:0] m, logic [7:0] s, logic [15:0] w);
			if (s == 0 && w == SYM_NOSUCHMAP) begin
				if (m != 0) map_live[m] = 0;
				return ST_OK;
			end
			if (w[15:8] >= TYPE_LIMIT || s == 0) return ST_INVAL;
			if (!map_live[m]) begin
				sym_store[{m, 8'd0}] = SYM_ALLOCATED;
				for (int i = 1; i < KEYS; i++) sym_store[{m, i[7:0]}] = SYM_HOLE;
				map_live[m] = 1;
			end
			sym_store[{m, s}] = w;
			return ST_OK;
		endfunction

		// predict results of one accepted transfer
		function void note_input(kbd_item_t it);
			logic [1:0] md, st;
			logic [15:0] rw;
			xlat_result_t r;
			int n0;
			n0 = pending.size();
			md = con_mode[active_con];
			st = ST_OK;
			rw = 0;
			case (it.cmd)
				CMD_KEY: begin
					if (md == MODE_XLATE) translate(it.key_code, it.key_down);
					else if (md == MODE_MRAW) begin
						if (it.key_code < 128)
							push_byte(it.key_code | (it.key_down ? 8'd0 : HIGH_BIT));
						else begin
							push_byte(it.key_down ? 8'd0 : HIGH_BIT);
							push_byte((it.key_code >> 7) | HIGH_BIT);
							push_byte(it.key_code | HIGH_BIT);
						end
					end
				end
				CMD_SCAN: if (md == MODE_RAW) push_byte(it.scan_byte);
				CMD_WRITE: st = write_sym(it.map_select, it.entry_slot, it.entry_word);
				CMD_READ: begin
					if (map_live[it.map_select]) begin
						rw = sym_store[{it.map_select, it.entry_slot}];
						if (rw[15:8] >= TYPE_LIMIT) rw = SYM_HOLE;
					end else rw = (it.entry_slot != 0) ? SYM_HOLE : SYM_NOSUCHMAP;
				end
				CMD_SETMD: begin
					if (it.console_index >= CONS) st = ST_NOCON;
					else if (it.mode_code > MODE_MRAW) st = ST_INVAL;
					else con_mode[it.console_index] = it.mode_code;
				end
				CMD_GETMD: begin
					if (it.console_index >= CONS) st = ST_NOCON;
					else rw = {14'd0, con_mode[it.console_index]};
				end
				CMD_ACT: begin
					if (it.console_index >= CONS) st = ST_NOCON;
					else active_con = it.console_index;
				end
				default: st = ST_INVAL;
			endcase
			if (it.cmd >= CMD_WRITE) begin
				r = '0;
				r.read_word = rw;
				r.status = st;
				pending.push_back(r);
			end
			for (int i = n0; i < pending.size(); i++)
				pending[i].target_console = active_con;
			if (pending.size() > n0) pending[pending.size() - 1].last = 1;
		endfunction

		task check_result(xlat_result_t got);
			xlat_result_t want;
			if (pending.size() == 0) begin
				report_mismatch("unexpected result", got.read_word, 16'h0);
				return;
			end
			want = pending.pop_front();
			if (got.byte_valid) bytes_seen++; else replies_seen++;
			if (got.out_byte !== want.out_byte)
				report_mismatch("out_byte", got.out_byte, want.out_byte);
			if (got.byte_valid !== want.byte_valid)
				report_mismatch("byte_valid", got.byte_valid, want.byte_valid);
			if (got.target_console !== want.target_console)
				report_mismatch("target_console", got.target_console, want.target_console);
			if (got.read_word !== want.read_word)
				report_mismatch("read_word", got.read_word, want.read_word);
			if (got.status !== want.status)
				report_mismatch("status", got.status, want.status);
			if (got.last !== want.last)
				report_mismatch("last", got.last, want.last);
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [2:0] cmd = 0;
	logic [7:0] key_code = 0;
	logic key_down = 0;
	logic [7:0] scan_byte = 0;
	logic [7:0] map_select = 0;
	logic [7:0] entry_slot = 0;
	logic [15:0] entry_word = 0;
	logic [3:0] console_index = 0;
	logic [1:0] mode_code = 0;
	logic strobe;
	logic [7:0] out_byte;
	logic byte_valid;
	logic [3:0] target_console;
	logic [15:0] read_word;
	logic [1:0] status;
	logic last;

	keymap_scoreboard sb;
	int cycle_count;
	int items_sent;

	always #5 clk = ~clk;

	keyboard_keymap_translator_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.key_code(key_code), .key_down(key_down), .scan_byte(scan_byte),
		.map_select(map_select), .entry_slot(entry_slot), .entry_word(entry_word),
		.console_index(console_index), .mode_code(mode_code), .strobe(strobe),
		.out_byte(out_byte), .byte_valid(byte_valid), .target_console(target_console),
		.read_word(read_word), .status(status), .last(last)
	);

	always @(posedge clk) begin
		if (arst_n && strobe)
			sb.check_result({out_byte, byte_valid, target_console, read_word, status, last});
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > TIMEOUT_CYCLES) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// start drops only when a real gap follows
	task automatic idle_gap();
		int n;
		if ($urandom_range(0, 3) == 0) return;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
		if (n == 0) return;
		start <= 0;
		repeat (n) @(posedge clk);
	endtask

	// hold start until the transfer completes
	task automatic send_item(kbd_item_t it, bit gaps);
		if (gaps) idle_gap();
		start <= 1;
		cmd <= it.cmd;
		key_code <= it.key_code;
		key_down <= it.key_down;
		scan_byte <= it.scan_byte;
		map_select <= it.map_select;
		entry_slot <= it.entry_slot;
		entry_word <= it.entry_word;
		console_index <= it.console_index;
		mode_code <= it.mode_code;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_input(it);
		items_sent++;
	endtask

	task automatic drain();
		start <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	function automatic kbd_item_t rand_item();
		kbd_item_t it;
		it.cmd = 3'($urandom_range(0, 7));
		it.key_code = 8'($urandom);
		it.key_down = 1'($urandom);
		it.scan_byte = 8'($urandom);
		it.map_select = 8'($urandom);
		it.entry_slot = 8'($urandom);
		it.entry_word = 16'($urandom);
		it.console_index = 4'($urandom);
		it.mode_code = 2'($urandom);
		return it;
	endfunction

	function automatic kbd_item_t mk(logic [2:0] c, logic [7:0] kc = 0, logic kd = 1,
			logic [7:0] m = 0, logic [7:0] s = 0, logic [15:0] w = 0,
			logic [3:0] ci = 0, logic [1:0] mc = 0);
		kbd_item_t it;
		it = rand_item();
		it.cmd = c;
		it.key_code = kc;
		it.key_down = kd;
		it.map_select = m;
		it.entry_slot = s;
		it.entry_word = w;
		it.console_index = ci;
		it.mode_code = mc;
		return it;
	endfunction

	// keysym biased toward handled types and small values
	function automatic logic [15:0] rand_sym();
		logic [7:0] t, v;
		case ($urandom_range(0, 7))
			0: t = TY_PLAIN;
			1: t = TY_ALPHA;
			2: t = TY_SPEC;
			3: t = TY_CONS;
			4: t = TY_CUR;
			5: t = TY_MODKEY;
			6: t = 8'($urandom_range(0, 14));
			default: t = 8'($urandom);
		endcase
		v = $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom);
		if (t == TY_MODKEY && $urandom_range(0, 1)) v = 8'($urandom_range(0, 1));
		return {t, v};
	endfunction

	initial begin
		kbd_item_t it;
		sb = new();
		sb.clear();
		error_count = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed
		send_item(mk(CMD_READ, 0, 1, 0, 0), 0);
		send_item(mk(CMD_READ, 0, 1, 8'd255, 8'd255), 0);
		send_item(mk(CMD_KEY, 8'd30, 1), 0);
		send_item(mk(CMD_WRITE, 0, 1, 0, 0, 16'h0041), 0);
		send_item(mk(CMD_WRITE, 0, 1, 0, 8'd1, 16'h0f00), 0);
		send_item(mk(CMD_WRITE, 0, 1, 0, 8'd10, 16'h0b61), 0);
		send_item(mk(CMD_WRITE, 0, 1, 0, 8'd11, 16'h0201), 0);
		send_item(mk(CMD_WRITE, 0, 1, 0, 8'd255, 16'h0603), 0);
		send_item(mk(CMD_WRITE, 0, 1, 0, 8'd12, 16'h0701), 0);
		send_item(mk(CMD_WRITE, 0, 1, 0, 8'd13, 16'h050b), 0);
		send_item(mk(CMD_WRITE, 0, 1, 8'd2, 8'd10, 16'h00ff), 0);
		send_item(mk(CMD_KEY, 8'd10, 1), 0);
		send_item(mk(CMD_KEY, 8'd11, 1), 0);
		send_item(mk(CMD_KEY, 8'd255, 1), 0);
		send_item(mk(CMD_KEY, 8'd12, 1), 0);
		send_item(mk(CMD_KEY, 8'd10, 1), 0);
		send_item(mk(CMD_KEY, 8'd12, 0), 0);
		send_item(mk(CMD_KEY, 8'd13, 1), 0);
		send_item(mk(CMD_SETMD, 0, 1, 0, 0, 0, 4'd11, MODE_MRAW), 0);
		send_item(mk(CMD_KEY, 8'd255, 0), 0);
		send_item(mk(CMD_SETMD, 0, 1, 0, 0, 0, 4'd11, MODE_RAW), 0);
		send_item(mk(CMD_SCAN), 0);
		send_item(mk(CMD_SETMD, 0, 1, 0, 0, 0, 4'd15, 2'd3), 0);
		send_item(mk(CMD_GETMD, 0, 1, 0, 0, 0, 4'd12), 0);
		send_item(mk(CMD_ACT, 0, 1, 0, 0, 0, 4'd12), 0);
		send_item(mk(3'd7), 0);
		send_item(mk(CMD_WRITE, 0, 1, 8'd2, 8'd0, SYM_NOSUCHMAP), 0);
		send_item(mk(CMD_WRITE, 0, 1, 8'd0, 8'd0, SYM_NOSUCHMAP), 0);
		send_item(mk(CMD_ACT, 0, 1, 0, 0, 0, 4'd0), 0);
		drain();

		// random: mostly structured traffic on a few small maps
		for (int i = 0; i < 300; i++) begin
			it = rand_item();
			case ($urandom_range(0, 9))
				0, 1: begin
					it.cmd = CMD_WRITE;
					it.map_select = 8'($urandom_range(0, 3));
					it.entry_slot = ($urandom_range(0, 15) == 0) ? 8'd0
						: 8'($urandom_range(1, 40));
					it.entry_word = rand_sym();
					if (it.entry_slot == 0 && $urandom_range(0, 1)) it.entry_word = SYM_NOSUCHMAP;
				end
				2, 3, 4: begin
					it.cmd = CMD_KEY;
					it.key_code = ($urandom_range(0, 3) == 0) ? 8'($urandom)
						: 8'($urandom_range(0, 40));
				end
				5: begin
					it.cmd = CMD_READ;
					if ($urandom_range(0, 1)) begin
						it.map_select = 8'($urandom_range(0, 3));
						it.entry_slot = 8'($urandom_range(0, 40));
					end
				end
				6: begin
					it.cmd = $urandom_range(0, 1) ? CMD_SETMD : CMD_ACT;
					it.console_index = 4'($urandom_range(0, 13));
				end
				default: ;
			endcase
			// a read of a live map may hit an entry never filled only when slot unfilled:
			// maps are always filled whole, so any slot is defined
			send_item(it, 1);
			if (i == 150) drain();
		end

		drain();
		$display("run covered %0d items: %0d bytes and %0d replies checked",
			items_sent, sb.bytes_seen, sb.replies_seen);
		if (error_count == 0 && sb.pending.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
